### rtl/core/rred_pkg.sv
// shared types, codes and code tables for the remote report event decoder
// no dependencies; imported by every module of the block
package rred_pkg;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // register index as seen on paddr[2]
   localparam logic REG_POINTER_GAIN = 1'b0;

   localparam logic [7:0]  GAIN_RESET = 8'd64;
   localparam logic [15:0] POS_RESET  = 16'd32767;
   localparam logic [15:0] POS_MAX    = 16'd65535;
   localparam logic [2:0]  REPORT_LEN = 3'd5;

   localparam logic [1:0] EV_REPORT  = 2'd0;
   localparam logic [1:0] EV_TIMEOUT = 2'd1;
   localparam logic [1:0] EV_GONE    = 2'd2;

   localparam logic [7:0] TYPE_POINTER = 8'h01;
   localparam logic [7:0] PTR_MOVE     = 8'h00;
   localparam logic [7:0] PTR_LEFT     = 8'h01;
   localparam logic [7:0] PTR_RIGHT    = 8'h02;

   localparam logic [3:0] ACT_KEY_ONCE = 4'd0;
   localparam logic [3:0] ACT_KEY_HELD = 4'd1;
   localparam logic [3:0] ACT_RELEASE  = 4'd2;
   localparam logic [3:0] ACT_POINTER  = 4'd3;
   localparam logic [3:0] ACT_INFO     = 4'd4;
   localparam logic [3:0] ACT_CONTEXT  = 4'd5;
   localparam logic [3:0] ACT_TITLE    = 4'd6;
   localparam logic [3:0] ACT_UNKNOWN  = 4'd7;
   localparam logic [3:0] ACT_GONE     = 4'd8;

   localparam logic [1:0] RIGHT_CLICK_START = 2'd2;

   // report bytes packed byte0 first
   localparam int unsigned NUM_REL = 3;
   localparam logic [39:0] REL_CODES [NUM_REL] = '{
      40'h02_00_00_00_55,
      40'h03_00_55_55_55,
      40'h01_00_00_00_00
   };

   localparam int unsigned NUM_KEYS = 9;
   localparam logic [39:0] KEY_CODES [NUM_KEYS] = '{
      40'h03_02_55_55_55,
      40'h02_02_00_00_55,
      40'h02_80_00_00_55,
      40'h02_00_02_00_55,
      40'h02_00_00_01_55,
      40'h02_00_00_02_55,
      40'h02_00_01_00_55,
      40'h02_10_00_00_55,
      40'h02_00_10_00_55
   };
   localparam logic [NUM_KEYS-1:0] KEY_REPEATS = 9'b1_1000_0000;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [2:0] report_length;
      logic [7:0] report_byte0;
      logic [7:0] report_byte1;
      logic [7:0] report_byte2;
      logic [7:0] report_byte3;
      logic [7:0] report_byte4;
   } req_type;

   typedef struct packed {
      logic [3:0]  action;
      logic [3:0]  key_index;
      logic [15:0] pointer_x;
      logic [15:0] pointer_y;
      logic        last_of_run;
   } rsp_type;

   // results of one decoded item, handed to the result queue
   typedef struct packed {
      logic [1:0] count;
      rsp_type    res0;
      rsp_type    res1;
   } decode_out_type;

endpackage

### rtl/core/remote_report_event_decoder.sv
// Remote report event decoder: an item is registered on entry, decoded against the
// decoder state by combinational logic and written as zero, one or two results into
// a four-entry result queue that drives the rsp_ port. A new item is taken every
// cycle while the queue has room for two results; with the result side always
// ready the block sustains one item per cycle for single-result items, while items
// that give two results are limited by the single result port. The first result of
// an item passes through the input register and the result queue before it is
// offered on rsp_, and the queue holds it there until rsp_ready takes it.
// pointer_gain (byte address 0) resets to 64 and should be written only while idle.
// depends on rred_pkg, rred_decode, rred_result_fifo
module remote_report_event_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rred_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rred_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rred_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [rred_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [rred_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import rred_pkg::*;

   logic           in_valid_ff, in_valid_in;
   req_type        in_item_ff;
   logic [7:0]     gain_ff;
   logic           fire;
   logic           room;
   logic           csr_write;
   decode_out_type dec;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == REG_POINTER_GAIN);
   assign prdata    = (paddr[2] == REG_POINTER_GAIN) ? {24'd0, gain_ff} : '0;

   assign fire      = in_valid_ff && room;
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         gain_ff     <= GAIN_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_write) begin
            gain_ff <= pwdata[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
   end

   rred_decode u_decode (
      .clock (clock),
      .reset (reset),
      .item  (in_item_ff),
      .fire  (fire),
      .gain  (gain_ff),
      .dec   (dec)
   );

   rred_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .dec       (dec),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/core/rred_decode.sv
// decode logic for one item plus the decoder state (repeat, right click, position)
// depends on rred_pkg
module rred_decode (
   input  logic                    clock,
   input  logic                    reset,
   input  rred_pkg::req_type       item,
   input  logic                    fire,
   input  logic [7:0]              gain,
   output rred_pkg::decode_out_type dec
);
   import rred_pkg::*;

   logic        repeat_armed_ff, repeat_armed_in;
   logic [1:0]  countdown_ff, countdown_in;
   logic [15:0] pos_x_ff, pos_x_in;
   logic [15:0] pos_y_ff, pos_y_in;

   logic [39:0] bytes;
   logic        is_rel;
   logic        hit;
   logic [3:0]  hit_idx;
   logic [15:0] moved_x, moved_y;
   rsp_type     res0, res1;
   logic [1:0]  n;

   function automatic logic [15:0] move_axis(logic [15:0] pos, logic [7:0] d, logic [7:0] g);
      logic signed [8:0]  ds;
      logic signed [8:0]  gs;
      logic signed [17:0] prod;
      logic signed [18:0] sum;
      ds   = {d[7], d};
      gs   = {1'b0, g};
      prod = ds * gs;
      sum  = $signed({3'b000, pos}) + $signed({prod[17], prod});
      if (sum[18]) begin
         move_axis = '0;
      end else if (|sum[17:16]) begin
         move_axis = POS_MAX;
      end else begin
         move_axis = sum[15:0];
      end
   endfunction

   assign bytes = {item.report_byte0, item.report_byte1, item.report_byte2,
                   item.report_byte3, item.report_byte4};

   always_comb begin
      is_rel = 1'b0;
      for (int i = 0; i < NUM_REL; i++) begin
         if (bytes == REL_CODES[i]) is_rel = 1'b1;
      end
   end

   // table entries are distinct; descending scan leaves the lowest match
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = NUM_KEYS - 1; i >= 0; i--) begin
         if (bytes == KEY_CODES[i]) begin
            hit     = 1'b1;
            hit_idx = 4'(i);
         end
      end
   end

   assign moved_x = move_axis(pos_x_ff, item.report_byte2, gain);
   assign moved_y = move_axis(pos_y_ff, item.report_byte3, gain);

   always_comb begin
      res0            = '0;
      res1            = '0;
      n               = '0;
      repeat_armed_in = repeat_armed_ff;
      countdown_in    = countdown_ff;
      pos_x_in        = pos_x_ff;
      pos_y_in        = pos_y_ff;
      if (item.event_kind == EV_GONE) begin
         res0.action = ACT_GONE;
         n           = 2'd1;
      end else if (item.event_kind == EV_TIMEOUT) begin
         if (countdown_ff == 2'd1) begin
            countdown_in = '0;
            res0.action  = ACT_INFO;
            n            = 2'd1;
         end
      end else if (item.event_kind == EV_REPORT && item.report_length == REPORT_LEN) begin
         if (is_rel) begin
            if (repeat_armed_ff) begin
               res0.action = ACT_RELEASE;
               n           = 2'd1;
            end
            if (countdown_ff != 2'd0) begin
               countdown_in = countdown_ff - 2'd1;
               if (countdown_ff == 2'd1) begin
                  if (repeat_armed_ff) begin
                     res1.action = ACT_CONTEXT;
                     n           = 2'd2;
                  end else begin
                     res0.action = ACT_CONTEXT;
                     n           = 2'd1;
                  end
               end
            end
         end else if (item.report_byte0 == TYPE_POINTER) begin
            if (item.report_byte1 == PTR_MOVE) begin
               if (item.report_byte2 != 8'd0 || item.report_byte3 != 8'd0) begin
                  pos_x_in       = moved_x;
                  pos_y_in       = moved_y;
                  res0.action    = ACT_POINTER;
                  res0.pointer_x = moved_x;
                  res0.pointer_y = moved_y;
                  n              = 2'd1;
               end
            end else if (item.report_byte1 == PTR_LEFT) begin
               res0.action = ACT_TITLE;
               n           = 2'd1;
            end else if (item.report_byte1 == PTR_RIGHT) begin
               countdown_in = RIGHT_CLICK_START;
            end
         end else if (hit) begin
            repeat_armed_in = KEY_REPEATS[hit_idx];
            res0.action     = KEY_REPEATS[hit_idx] ? ACT_KEY_HELD : ACT_KEY_ONCE;
            res0.key_index  = hit_idx;
            n               = 2'd1;
         end else begin
            res0.action = ACT_UNKNOWN;
            n           = 2'd1;
         end
      end
      res0.last_of_run = (n == 2'd1);
      res1.last_of_run = (n == 2'd2);
   end

   assign dec.count = n;
   assign dec.res0  = res0;
   assign dec.res1  = res1;

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_armed_ff <= 1'b0;
         countdown_ff    <= '0;
         pos_x_ff        <= POS_RESET;
         pos_y_ff        <= POS_RESET;
      end else if (fire) begin
         repeat_armed_ff <= repeat_armed_in;
         countdown_ff    <= countdown_in;
         pos_x_ff        <= pos_x_in;
         pos_y_ff        <= pos_y_in;
      end
   end

endmodule

### rtl/core/rred_result_fifo.sv
// small result queue: takes up to two results a cycle, hands out one
// depends on rred_pkg
module rred_result_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  rred_pkg::decode_out_type dec,
   output logic                     room,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rred_pkg::rsp_type        rsp_data
);
   import rred_pkg::*;

   rsp_type                entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  count_ff, count_in;
   logic [1:0]             push_n;
   logic                   pop;
   logic [FIFO_PTR_W-1:0]  wr_ptr_next;

   assign push_n      = push ? dec.count : 2'd0;
   assign pop         = rsp_valid && rsp_ready;
   assign wr_ptr_next = wr_ptr_ff + FIFO_PTR_W'(1);

   // room for a worst-case item of two results, counting a result leaving this cycle
   assign room = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2))
              || (pop && count_ff == FIFO_CNT_W'(FIFO_DEPTH - 1));

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
   assign count_in  = count_ff + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entry_ff[wr_ptr_ff] <= dec.res0;
      end
      if (push_n == 2'd2) begin
         entry_ff[wr_ptr_next] <= dec.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/core/rred_checker.sv
// port-level checks for the remote report event decoder, bound to the top level
// depends on rred_pkg and remote_report_event_decoder
module rred_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input rred_pkg::rsp_type               rsp_data
);
   import rred_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_action_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.action <= ACT_GONE)
      else $error("action code out of range");

   a_pos_only_pointer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action != ACT_POINTER |->
         rsp_data.pointer_x == '0 && rsp_data.pointer_y == '0)
      else $error("position on a non-pointer result");

   a_key_only_keys: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action != ACT_KEY_ONCE && rsp_data.action != ACT_KEY_HELD
         |-> rsp_data.key_index == '0)
      else $error("key index on a non-key result");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_of_run |=> rsp_valid)
      else $error("item run ended without its last result");

endmodule

bind remote_report_event_decoder rred_checker u_rred_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
